// ===== rtl/core/assert_macros.svh =====
// Assertion macros shared by the tokenizer RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock, off during reset
`define ILT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, sampled on the rising clock, off during reset
`define ILT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== rtl/core/ilt_pkg.sv =====
// Types, codes and constants of the IRC line tokenizer
package ilt_pkg;

    localparam logic [2:0] KIND_SEP   = 3'd0;
    localparam logic [2:0] KIND_NICK  = 3'd1;
    localparam logic [2:0] KIND_USER  = 3'd2;
    localparam logic [2:0] KIND_HOST  = 3'd3;
    localparam logic [2:0] KIND_CMD   = 3'd4;
    localparam logic [2:0] KIND_MID   = 3'd5;
    localparam logic [2:0] KIND_TRAIL = 3'd6;

    localparam logic [1:0] STATUS_OK    = 2'd0;
    localparam logic [1:0] STATUS_EMPTY = 2'd1;
    localparam logic [1:0] STATUS_BLANK = 2'd2;

    localparam logic [7:0] CH_NUL   = 8'h00;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_AT    = 8'h40;

    // queue between front and back; depth must be a power of two
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);
    localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

    typedef enum logic [9:0] {
        MODE_LEAD  = 10'b00_0000_0001,
        MODE_NICK  = 10'b00_0000_0010,
        MODE_USER  = 10'b00_0000_0100,
        MODE_HOST  = 10'b00_0000_1000,
        MODE_CSKIP = 10'b00_0001_0000,
        MODE_CMD   = 10'b00_0010_0000,
        MODE_PSKIP = 10'b00_0100_0000,
        MODE_PARAM = 10'b00_1000_0000,
        MODE_TRAIL = 10'b01_0000_0000,
        MODE_DONE  = 10'b10_0000_0000
    } t_mode;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] chr;
        logic       chr_valid;
        logic       start;
        logic       last;
        logic [1:0] status;
    } t_tag;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

endpackage

// ===== rtl/core/ilt_front.sv =====
// Front end: accepts bytes, tracks the parse mode and tags each byte
module ilt_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte_in,
    input  logic          i_last_byte,
    input  logic          i_full,
    output logic          o_stall,
    output logic          o_push,
    output ilt_pkg::t_tag o_tag
);

    ilt_pkg::t_mode r_mode, n_mode;
    logic           r_seen_nonblank, n_seen_nonblank;
    logic           r_seen_any, n_seen_any;
    logic           accept;
    logic           blank;
    logic           active;
    logic [2:0]     kind;
    logic           start;
    logic           chr_valid;
    logic           parse_nb;
    logic           parse_any;

    assign accept  = i_valid && !i_full;
    assign o_stall = i_full;
    assign o_push  = accept;

    assign blank  = (i_byte_in == ilt_pkg::CH_SPACE) || (i_byte_in == ilt_pkg::CH_TAB);
    assign active = (i_byte_in != ilt_pkg::CH_NUL) && (r_mode != ilt_pkg::MODE_DONE);

    always_comb begin
        kind      = ilt_pkg::KIND_SEP;
        start     = 1'b0;
        chr_valid = 1'b0;
        n_mode    = r_mode;
        if (!active) begin
            n_mode = ilt_pkg::MODE_DONE;
        end else begin
            case (r_mode)
                ilt_pkg::MODE_LEAD: begin
                    if (!blank) begin
                        if (i_byte_in == ilt_pkg::CH_COLON) begin
                            kind   = ilt_pkg::KIND_NICK;
                            start  = 1'b1;
                            n_mode = ilt_pkg::MODE_NICK;
                        end else begin
                            kind      = ilt_pkg::KIND_CMD;
                            start     = 1'b1;
                            chr_valid = 1'b1;
                            n_mode    = ilt_pkg::MODE_CMD;
                        end
                    end
                end
                ilt_pkg::MODE_NICK: begin
                    if (i_byte_in == ilt_pkg::CH_BANG) begin
                        kind   = ilt_pkg::KIND_USER;
                        start  = 1'b1;
                        n_mode = ilt_pkg::MODE_USER;
                    end else if (i_byte_in == ilt_pkg::CH_AT) begin
                        kind   = ilt_pkg::KIND_HOST;
                        start  = 1'b1;
                        n_mode = ilt_pkg::MODE_HOST;
                    end else if (blank) begin
                        n_mode = ilt_pkg::MODE_CSKIP;
                    end else begin
                        kind      = ilt_pkg::KIND_NICK;
                        chr_valid = 1'b1;
                    end
                end
                ilt_pkg::MODE_USER: begin
                    if (i_byte_in == ilt_pkg::CH_AT) begin
                        kind   = ilt_pkg::KIND_HOST;
                        start  = 1'b1;
                        n_mode = ilt_pkg::MODE_HOST;
                    end else if (blank) begin
                        n_mode = ilt_pkg::MODE_CSKIP;
                    end else begin
                        kind      = ilt_pkg::KIND_USER;
                        chr_valid = 1'b1;
                    end
                end
                ilt_pkg::MODE_HOST: begin
                    if (blank) begin
                        n_mode = ilt_pkg::MODE_CSKIP;
                    end else begin
                        kind      = ilt_pkg::KIND_HOST;
                        chr_valid = 1'b1;
                    end
                end
                ilt_pkg::MODE_CSKIP: begin
                    if (!blank) begin
                        kind      = ilt_pkg::KIND_CMD;
                        start     = 1'b1;
                        chr_valid = 1'b1;
                        n_mode    = ilt_pkg::MODE_CMD;
                    end
                end
                ilt_pkg::MODE_CMD: begin
                    if (blank) begin
                        n_mode = ilt_pkg::MODE_PSKIP;
                    end else begin
                        kind      = ilt_pkg::KIND_CMD;
                        chr_valid = 1'b1;
                    end
                end
                ilt_pkg::MODE_PSKIP: begin
                    if (!blank) begin
                        if (i_byte_in == ilt_pkg::CH_COLON) begin
                            kind   = ilt_pkg::KIND_TRAIL;
                            start  = 1'b1;
                            n_mode = ilt_pkg::MODE_TRAIL;
                        end else begin
                            kind      = ilt_pkg::KIND_MID;
                            start     = 1'b1;
                            chr_valid = 1'b1;
                            n_mode    = ilt_pkg::MODE_PARAM;
                        end
                    end
                end
                ilt_pkg::MODE_PARAM: begin
                    if (blank) begin
                        n_mode = ilt_pkg::MODE_PSKIP;
                    end else begin
                        kind      = ilt_pkg::KIND_MID;
                        chr_valid = 1'b1;
                    end
                end
                ilt_pkg::MODE_TRAIL: begin
                    kind      = ilt_pkg::KIND_TRAIL;
                    chr_valid = 1'b1;
                end
                default: begin
                    n_mode = ilt_pkg::MODE_DONE;
                end
            endcase
        end

        parse_any = r_seen_any || active;
        parse_nb  = r_seen_nonblank || (active && !blank);

        // line end: report status and return to line start
        if (i_last_byte) begin
            n_mode          = ilt_pkg::MODE_LEAD;
            n_seen_any      = 1'b0;
            n_seen_nonblank = 1'b0;
        end else begin
            n_seen_any      = parse_any;
            n_seen_nonblank = parse_nb;
        end
    end

    always_comb begin
        o_tag.kind      = kind;
        o_tag.chr       = i_byte_in;
        o_tag.chr_valid = chr_valid;
        o_tag.start     = start;
        o_tag.last      = i_last_byte;
        if (!i_last_byte) begin
            o_tag.status = ilt_pkg::STATUS_OK;
        end else if (!parse_any) begin
            o_tag.status = ilt_pkg::STATUS_EMPTY;
        end else if (!parse_nb) begin
            o_tag.status = ilt_pkg::STATUS_BLANK;
        end else begin
            o_tag.status = ilt_pkg::STATUS_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode          <= ilt_pkg::MODE_LEAD;
            r_seen_nonblank <= 1'b0;
            r_seen_any      <= 1'b0;
        end else if (accept) begin
            r_mode          <= n_mode;
            r_seen_nonblank <= n_seen_nonblank;
            r_seen_any      <= n_seen_any;
        end
    end

endmodule

// ===== rtl/core/ilt_queue.sv =====
// Short queue of tagged bytes between front and back
module ilt_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ilt_pkg::t_tag    i_wdata,
    input  logic             i_pop,
    output ilt_pkg::t_tag    o_rdata,
    output ilt_pkg::t_q_stat o_stat
);

    ilt_pkg::t_tag                 r_mem [ilt_pkg::Q_DEPTH];
    logic [ilt_pkg::Q_PTR_W-1:0]   r_wptr, r_rptr;
    logic [ilt_pkg::Q_CNT_W-1:0]   r_count, n_count;

    assign o_rdata      = r_mem[r_rptr];
    assign o_stat.full  = (r_count == ilt_pkg::Q_CNT_W'(ilt_pkg::Q_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            r_count <= n_count;
        end
    end

endmodule

// ===== rtl/core/ilt_back.sv =====
// Back end: drains the queue into the output register
module ilt_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  ilt_pkg::t_tag i_head,
    input  logic          i_not_empty,
    input  logic          i_stall,
    output logic          o_pop,
    output logic          o_valid,
    output logic [2:0]    o_field_kind,
    output logic [7:0]    o_char_out,
    output logic          o_char_valid,
    output logic          o_token_start,
    output logic          o_line_end,
    output logic [1:0]    o_status
);

    logic r_valid;

    // load when the register is empty or its transfer completes now
    assign o_pop   = i_not_empty && (!r_valid || !i_stall);
    assign o_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            o_field_kind  <= i_head.kind;
            o_char_out    <= i_head.chr_valid ? i_head.chr : ilt_pkg::CH_NUL;
            o_char_valid  <= i_head.chr_valid;
            o_token_start <= i_head.start;
            o_line_end    <= i_head.last;
            o_status      <= i_head.status;
        end
    end

endmodule

// ===== rtl/core/irc_line_tokenizer.sv =====
// Top level of the IRC line tokenizer: front end, queue and back end
//
//   channel   valid     stall     payload
//   in        i_valid   o_stall   i_byte_in, i_last_byte
//   out       o_valid   i_stall   o_field_kind, o_char_out, o_char_valid,
//                                 o_token_start, o_line_end, o_status
//
// One byte per cycle sustained while the output is not stalled; a transferred
// byte is written into the queue and then loaded into the output register.
// The front end takes a byte whenever the two-entry queue is not full.
// Reset returns the parser to line start and empties queue and output.
// An output stall fills the queue first; the input stalls only once it is full.
`include "assert_macros.svh"

module irc_line_tokenizer (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_byte_in,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_field_kind,
    output logic [7:0] o_char_out,
    output logic       o_char_valid,
    output logic       o_token_start,
    output logic       o_line_end,
    output logic [1:0] o_status
);

    ilt_pkg::t_tag    push_tag;
    ilt_pkg::t_tag    head_tag;
    ilt_pkg::t_q_stat q_stat;
    logic             push;
    logic             pop;
    logic             end_status;
    logic             end_sep;

    ilt_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_byte_in   (i_byte_in),
        .i_last_byte (i_last_byte),
        .i_full      (q_stat.full),
        .o_stall     (o_stall),
        .o_push      (push),
        .o_tag       (push_tag)
    );

    ilt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_wdata (push_tag),
        .i_pop   (pop),
        .o_rdata (head_tag),
        .o_stat  (q_stat)
    );

    ilt_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head_tag),
        .i_not_empty   (!q_stat.empty),
        .i_stall       (i_stall),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .o_field_kind  (o_field_kind),
        .o_char_out    (o_char_out),
        .o_char_valid  (o_char_valid),
        .o_token_start (o_token_start),
        .o_line_end    (o_line_end),
        .o_status      (o_status)
    );

    assign end_status = o_valid && (o_status != ilt_pkg::STATUS_OK);
    assign end_sep    = o_line_end && (o_field_kind == ilt_pkg::KIND_SEP);

    `ILT_ASSERT_NOW(a_q_stat_sane, 1'b1, !(q_stat.full && q_stat.empty))
    `ILT_ASSERT_NEXT(a_push_lands, i_valid && !o_stall && q_stat.empty, !q_stat.empty)
    `ILT_ASSERT_NOW(a_status_on_end, end_status, end_sep)
    `ILT_ASSERT_NOW(a_char_has_kind, o_valid && o_char_valid, o_field_kind != ilt_pkg::KIND_SEP)

endmodule
